### hdl/i2cdw_pkg.sv
// ----------------------------------------------------------------------------
// i2cdw_pkg
// Shared types and constants of the I2C display write serializer.
// ----------------------------------------------------------------------------
package i2cdw_pkg;

    // line symbols
    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_BIT   = 2'd1,
        SYM_ACK   = 2'd2,
        SYM_STOP  = 2'd3
    } t_symbol;

    typedef struct packed {
        logic       operation;
        logic [7:0] payload;
    } t_item;

    typedef struct packed {
        t_symbol symbol;
        logic    sda_level;
        logic    last;
    } t_result;

    // one framed transaction: three bytes sent MSB first
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] data;
    } t_frame;

    // valid/ready pair between front and queue
    typedef struct packed {
        logic vld;
        logic rdy;
    } t_hs;

    localparam logic       OP_COMMAND     = 1'b0;
    localparam logic       OP_DATA        = 1'b1;
    localparam logic [7:0] CTRL_COMMAND   = 8'h00;
    localparam logic [7:0] CTRL_DATA      = 8'h40;
    localparam logic [7:0] DEV_ADDR_RESET = 8'h78;

    localparam int         PADDR_W        = 3;
    localparam logic       REG_DEV_ADDR   = 1'b0;

    localparam int         QUEUE_DEPTH    = 2;

endpackage

### hdl/i2c_display_write_serializer.sv
// ----------------------------------------------------------------------------
// i2c_display_write_serializer
// Frames display command/data bytes as write-only I2C line symbol sequences.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): one word is a display byte plus a command/data
//   flag. Output queue (empty/pop): one word is a line symbol (start, data
//   bit, ack clock, stop) with its SDA level; the stop symbol carries last.
//   Each input word expands to 29 symbols: start, address byte, control
//   byte (0x00 command, 0x40 data), payload byte, each plus an ack clock,
//   then stop.
//   The start symbol passes the front register, frame queue and output register.
//   Throughput: one symbol per cycle while pop stays high, set by the
//   symbol sequencer; up to three further words wait in the front register
//   and frame queue while a frame goes out.
//   A stalled output (pop low) holds the current symbol and freezes the
//   sequencer; full rises once the front and queue fill. Reset empties all
//   stages and loads the device address register with 0x78. The APB register
//   (address 0) must be written only while idle, not enforced by the block.
// ----------------------------------------------------------------------------
module i2c_display_write_serializer #(
    parameter int QUEUE_DEPTH = i2cdw_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  i2cdw_pkg::t_item                  i_item,
    output logic                              empty,
    input  logic                              pop,
    output i2cdw_pkg::t_result                o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cdw_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [7:0]        r_dev_addr_byte;
    i2cdw_pkg::t_hs    hs_ctl;
    i2cdw_pkg::t_frame front_frame;
    i2cdw_pkg::t_frame q_frame;
    logic              q_ready;
    logic              q_vld;
    logic              q_rd;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == i2cdw_pkg::REG_DEV_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr_byte <= i2cdw_pkg::DEV_ADDR_RESET;
        end else begin
            if (psel && penable && pwrite && pready && reg_sel) begin
                r_dev_addr_byte <= pwdata[7:0];
            end
        end
    end

    assign prdata = reg_sel ? {24'd0, r_dev_addr_byte} : 32'd0;

    i2cdw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .i_dev_addr (r_dev_addr_byte),
        .o_hs_ctl   (hs_ctl),
        .i_q_ready  (q_ready),
        .o_frame    (front_frame)
    );

    i2cdw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hs_ctl (hs_ctl),
        .i_wdata  (front_frame),
        .o_ready  (q_ready),
        .o_vld    (q_vld),
        .o_rdata  (q_frame),
        .i_rd     (q_rd)
    );

    i2cdw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (q_vld),
        .i_frame  (q_frame),
        .o_q_rd   (q_rd),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule

### hdl/i2cdw_front.sv
// ----------------------------------------------------------------------------
// i2cdw_front
// Accepts a display byte, picks the control byte and builds the frame.
// ----------------------------------------------------------------------------
module i2cdw_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  i2cdw_pkg::t_item      i_item,
    input  logic [7:0]            i_dev_addr,
    output i2cdw_pkg::t_hs        o_hs_ctl,
    input  logic                  i_q_ready,
    output i2cdw_pkg::t_frame     o_frame
);

    logic              r_vld;
    i2cdw_pkg::t_frame r_frame;
    logic              n_vld;
    logic              accept;

    assign o_full = r_vld && !i_q_ready;
    assign accept = i_push && !o_full;

    always_comb begin
        n_vld = r_vld;
        if (r_vld && i_q_ready) begin
            n_vld = 1'b0;
        end
        if (accept) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_frame.addr <= i_dev_addr;
            r_frame.ctrl <= (i_item.operation == i2cdw_pkg::OP_DATA) ?
                            i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_COMMAND;
            r_frame.data <= i_item.payload;
        end
    end

    assign o_hs_ctl.vld = r_vld;
    assign o_hs_ctl.rdy = i_q_ready;
    assign o_frame      = r_frame;

endmodule

### hdl/i2cdw_fifo.sv
// ----------------------------------------------------------------------------
// i2cdw_fifo
// Short frame queue between the front and the symbol sequencer.
// ----------------------------------------------------------------------------
module i2cdw_fifo #(
    parameter int DEPTH = i2cdw_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2cdw_pkg::t_hs     i_hs_ctl,
    input  i2cdw_pkg::t_frame  i_wdata,
    output logic               o_ready,
    output logic               o_vld,
    output i2cdw_pkg::t_frame  o_rdata,
    input  logic               i_rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    i2cdw_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              wr;
    logic              rd;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_vld   = (r_cnt != '0);
    assign wr      = i_hs_ctl.vld && i_hs_ctl.rdy;
    assign rd      = i_rd && o_vld;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### hdl/i2cdw_back.sv
// ----------------------------------------------------------------------------
// i2cdw_back
// Symbol sequencer: 29 line symbols per frame, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module i2cdw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_vld,
    input  i2cdw_pkg::t_frame   i_frame,
    output logic                o_q_rd,
    output logic                o_empty,
    input  logic                i_pop,
    output i2cdw_pkg::t_result  o_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIT,
        ST_ACK,
        ST_STOP
    } t_state;

    t_state             r_state;
    logic [23:0]        r_sh;
    logic [2:0]         r_bit;
    logic [1:0]         r_byte;
    logic               r_last_bit;
    logic               r_out_vld;
    i2cdw_pkg::t_result r_out;
    logic               advance;

    // output stage frees up when empty or taken this cycle
    assign advance = !r_out_vld || i_pop;
    assign o_q_rd  = advance && (r_state == ST_IDLE) && i_q_vld;
    assign o_empty = !r_out_vld;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_vld  <= 1'b0;
            r_bit      <= '0;
            r_byte     <= '0;
            r_last_bit <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_vld) begin
                        r_sh            <= {i_frame.addr, i_frame.ctrl, i_frame.data};
                        r_out.symbol    <= i2cdw_pkg::SYM_START;
                        r_out.sda_level <= 1'b0;
                        r_out.last      <= 1'b0;
                        r_out_vld       <= 1'b1;
                        r_bit           <= '0;
                        r_byte          <= '0;
                        r_state         <= ST_BIT;
                    end
                end
                ST_BIT: begin
                    r_out.symbol    <= i2cdw_pkg::SYM_BIT;
                    r_out.sda_level <= r_sh[23];
                    r_out.last      <= 1'b0;
                    r_out_vld       <= 1'b1;
                    r_last_bit      <= r_sh[23];
                    r_sh            <= {r_sh[22:0], 1'b0};
                    r_bit           <= r_bit + 1'b1;
                    if (r_bit == 3'd7) begin
                        r_state <= ST_ACK;
                    end
                end
                ST_ACK: begin
                    // SDA holds the byte's last bit through the ack clock
                    r_out.symbol    <= i2cdw_pkg::SYM_ACK;
                    r_out.sda_level <= r_last_bit;
                    r_out.last      <= 1'b0;
                    r_out_vld       <= 1'b1;
                    r_byte          <= r_byte + 1'b1;
                    r_state         <= (r_byte == 2'd2) ? ST_STOP : ST_BIT;
                end
                ST_STOP: begin
                    r_out.symbol    <= i2cdw_pkg::SYM_STOP;
                    r_out.sda_level <= 1'b0;
                    r_out.last      <= 1'b1;
                    r_out_vld       <= 1'b1;
                    r_state         <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/i2cdw_checker.sv
// ----------------------------------------------------------------------------
// i2cdw_checker
// Port-level checks of the I2C display write serializer.
// ----------------------------------------------------------------------------
module i2cdw_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               empty,
    input  logic               pop,
    input  logic               pready,
    input  i2cdw_pkg::t_result o_result
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled word changed");

    a_last_on_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.last == (o_result.symbol == i2cdw_pkg::SYM_STOP)))
        else $error("last flag not on stop symbol");

    a_cond_sda_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.symbol == i2cdw_pkg::SYM_START ||
                    o_result.symbol == i2cdw_pkg::SYM_STOP)) |-> !o_result.sda_level)
        else $error("sda high on start or stop");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind i2c_display_write_serializer i2cdw_checker u_i2cdw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .pready   (pready),
    .o_result (o_result)
);

### verif/i2c_display_write_serializer_checker.sv
// ----------------------------------------------------------------------------
// i2c_display_write_serializer_checker
// Watches the item, symbol and register channels of the serializer, builds
// the I2C line symbols every accepted word must produce and compares each
// popped symbol word against the oldest one due.
// ----------------------------------------------------------------------------
module i2c_display_write_serializer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  i2cdw_pkg::t_item               i_item,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  i2cdw_pkg::t_result             i_result,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [i2cdw_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [31:0]                    i_pwdata,
    input  logic [31:0]                    i_prdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int REPORT_LIMIT = 10;

    i2cdw_pkg::t_result symbols_due[$];
    logic [7:0]         dev_addr_copy;
    int                 error_total;
    int                 symbols_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        error_total  = 0;
        symbols_seen = 0;
        dev_addr_copy = i2cdw_pkg::DEV_ADDR_RESET;
    end

    task automatic push_symbol(input i2cdw_pkg::t_symbol sym, input logic sda,
                               input logic fin);
        i2cdw_pkg::t_result r;
        r.symbol    = sym;
        r.sda_level = sda;
        r.last      = fin;
        symbols_due.push_back(r);
    endtask

    // MSB first, then the ack clock holding the last bit sent
    task automatic push_octet(input logic [7:0] octet);
        logic b;
        b = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            b = octet[k];
            push_symbol(i2cdw_pkg::SYM_BIT, b, 1'b0);
        end
        push_symbol(i2cdw_pkg::SYM_ACK, b, 1'b0);
    endtask

    task automatic queue_frame_symbols(input i2cdw_pkg::t_item w);
        push_symbol(i2cdw_pkg::SYM_START, 1'b0, 1'b0);
        push_octet(dev_addr_copy);
        push_octet((w.operation == i2cdw_pkg::OP_DATA) ?
                   i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_COMMAND);
        push_octet(w.payload);
        push_symbol(i2cdw_pkg::SYM_STOP, 1'b0, 1'b1);
    endtask

    always @(posedge i_clk) begin : watch
        i2cdw_pkg::t_result want;
        if (!i_rst_n) begin
            symbols_due.delete();
            dev_addr_copy = i2cdw_pkg::DEV_ADDR_RESET;
        end else begin
            if (i_psel && i_penable && i_pready
                    && i_paddr[i2cdw_pkg::PADDR_W-1:2] == i2cdw_pkg::REG_DEV_ADDR) begin
                if (i_pwrite) begin
                    dev_addr_copy = i_pwdata[7:0];
                end else if (i_prdata[7:0] !== dev_addr_copy) begin
                    if (error_total < REPORT_LIMIT)
                        $display("[%0t] address register read: expected %02h, got %02h",
                                 $time, dev_addr_copy, i_prdata[7:0]);
                    error_total++;
                end
            end

            // check before queuing: a word accepted now cannot show yet
            if (i_pop && !i_empty) begin
                if (symbols_due.size() == 0) begin
                    if (error_total < REPORT_LIMIT)
                        $display("[%0t] symbol word %0d with none due: %s%0d %s%0b %s%0b",
                                 $time, symbols_seen, "sym=", i_result.symbol,
                                 "sda=", i_result.sda_level, "last=", i_result.last);
                    error_total++;
                end else begin
                    want = symbols_due.pop_front();
                    if (i_result.symbol !== want.symbol
                            || i_result.sda_level !== want.sda_level
                            || i_result.last !== want.last) begin
                        if (error_total < REPORT_LIMIT) begin
                            $display("[%0t] symbol word %0d: expected sym=%0d sda=%0b last=%0b",
                                     $time, symbols_seen, want.symbol, want.sda_level,
                                     want.last);
                            $display("        got sym=%0d sda=%0b last=%0b",
                                     i_result.symbol, i_result.sda_level, i_result.last);
                        end
                        error_total++;
                    end
                end
                symbols_seen++;
            end

            if (i_push && !i_full)
                queue_frame_symbols(i_item);
        end
        o_fail_count <= error_total;
        o_pending    <= symbols_due.size();
    end

endmodule

### verif/i2c_display_write_serializer_test.sv
// ----------------------------------------------------------------------------
// i2c_display_write_serializer_test
// Drives command and data bytes into the serializer under random push and pop
// gaps, rewrites the device address between phases and leaves the symbol
// checking to the checker module; one long output stall fills the block.
// ----------------------------------------------------------------------------
module i2c_display_write_serializer_test;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_WORDS    = 42;
    localparam int CALM_PHASE     = 2;
    localparam int PRESSURE_PHASE = 4;

    localparam logic [i2cdw_pkg::PADDR_W-1:0] ADDR_DEV   =
        {i2cdw_pkg::REG_DEV_ADDR, 2'b00};
    localparam logic [i2cdw_pkg::PADDR_W-1:0] ADDR_SPARE =
        {~i2cdw_pkg::REG_DEV_ADDR, 2'b00};

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push    = 1'b0;
    logic                          full;
    i2cdw_pkg::t_item              item_word = '0;
    logic                          empty;
    logic                          pop     = 1'b0;
    i2cdw_pkg::t_result            result_word;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [i2cdw_pkg::PADDR_W-1:0] paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    int  fail_count;
    int  pending;
    int  stall_count = 0;
    int  rx_wait     = 0;
    bit  rx_calm     = 1'b0;
    bit  hold_req    = 1'b0;
    bit  hold_taken  = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    i2c_display_write_serializer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (item_word),
        .empty    (empty),
        .pop      (pop),
        .o_result (result_word),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    i2c_display_write_serializer_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item_word),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin : rx_side
        int gap;
        if (!i_rst_n) begin
            pop     <= 1'b0;
            rx_wait <= 0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            rx_wait    <= HOLD_CYCLES;
            pop        <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
        end else if (pop && !empty) begin
            gap = idle_len(rx_calm);
            if (gap != 0) begin
                pop     <= 1'b0;
                rx_wait <= gap;
            end
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("i2c_display_write_serializer test failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send_word(input logic op, input logic [7:0] data, input bit calm);
        i2cdw_pkg::t_item w;
        int gap;
        w.operation = op;
        w.payload   = data;
        push      <= 1'b1;
        item_word <= w;
        do @(posedge i_clk); while (full);
        gap = idle_len(calm);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [i2cdw_pkg::PADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop push and wait out the symbols still due plus the pipeline
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [31:0] addr_val;
        bit          tx_calm;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset address, both operations, payload extremes and alternating bits
        send_word(i2cdw_pkg::OP_COMMAND, 8'h00, 1'b0);
        send_word(i2cdw_pkg::OP_DATA,    8'hFF, 1'b0);
        send_word(i2cdw_pkg::OP_COMMAND, 8'hFF, 1'b0);
        send_word(i2cdw_pkg::OP_DATA,    8'h00, 1'b0);
        send_word(i2cdw_pkg::OP_COMMAND, 8'hA5, 1'b0);
        send_word(i2cdw_pkg::OP_DATA,    8'h5A, 1'b0);
        send_word(i2cdw_pkg::OP_DATA,    8'h01, 1'b0);
        send_word(i2cdw_pkg::OP_COMMAND, 8'h80, 1'b0);
        settle();
        apb_access(1'b0, ADDR_DEV, '0);

        // high bits of the write data must be dropped
        apb_access(1'b1, ADDR_DEV, 32'hFFFF_FF00);
        apb_access(1'b0, ADDR_DEV, '0);
        send_word(i2cdw_pkg::OP_COMMAND, 8'h3C, 1'b0);
        send_word(i2cdw_pkg::OP_DATA,    8'hC3, 1'b0);
        settle();

        apb_access(1'b1, ADDR_DEV, 32'h0000_00FF);
        send_word(i2cdw_pkg::OP_DATA,    8'h96, 1'b0);
        send_word(i2cdw_pkg::OP_COMMAND, 8'h69, 1'b0);
        settle();

        // unmapped slot: address must stay unchanged
        apb_access(1'b1, ADDR_SPARE, 32'h0000_0012);
        apb_access(1'b0, ADDR_DEV, '0);
        send_word(i2cdw_pkg::OP_COMMAND, 8'h7E, 1'b0);
        send_word(i2cdw_pkg::OP_DATA,    8'h81, 1'b0);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            addr_val = (ph == RANDOM_PHASES - 1) ?
                       32'(i2cdw_pkg::DEV_ADDR_RESET) : $urandom;
            apb_access(1'b1, ADDR_DEV, addr_val);
            apb_access(1'b0, ADDR_DEV, '0);
            tx_calm = (ph == CALM_PHASE) || (ph == PRESSURE_PHASE);
            rx_calm <= (ph == CALM_PHASE);
            if (ph == PRESSURE_PHASE)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(1'($urandom), 8'($urandom), tx_calm);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("i2c_display_write_serializer test passed");
        end else begin
            $display("i2c_display_write_serializer test failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/i2cdw_pkg.sv
hdl/i2cdw_front.sv
hdl/i2cdw_fifo.sv
hdl/i2cdw_back.sv
hdl/i2c_display_write_serializer.sv
hdl/i2cdw_checker.sv
verif/i2c_display_write_serializer_checker.sv
verif/i2c_display_write_serializer_test.sv
